@@ sv/adsr_pkg.sv @@
package adsr_pkg;

    // Envelope stage, as reported on the result channel
    typedef enum logic [2:0] {
        STG_SILENT  = 3'd0,
        STG_ATTACK  = 3'd1,
        STG_DECAY   = 3'd2,
        STG_SUSTAIN = 3'd3,
        STG_RELEASE = 3'd4
    } stage_t;

    // Item kinds
    typedef enum logic [1:0] {
        FN_SAMPLE   = 2'd0,
        FN_GATE_ON  = 2'd1,
        FN_GATE_OFF = 2'd2,
        FN_TABLE_WR = 2'd3
    } func_t;

    // Sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SKIP,
        ST_DIV,
        ST_RD,
        ST_SUM,
        ST_MUL,
        ST_SCALE,
        ST_HOLD_RD,
        ST_HOLD,
        ST_OUT
    } state_t;

    // Configuration register indexes
    localparam logic [1:0] REG_ATTACK_LEN  = 2'd0;
    localparam logic [1:0] REG_DECAY_LEN   = 2'd1;
    localparam logic [1:0] REG_SUSTAIN_LEN = 2'd2;
    localparam logic [1:0] REG_RELEASE_LEN = 2'd3;

    localparam int LEN_W   = 24;
    localparam int SMP_W   = 16;
    localparam int GAIN_W  = 24;
    localparam int PROD_W  = 40;
    localparam int GAIN_QW = 23;  // quotient bits of the gain division
    localparam int CNT_W   = 5;

    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 24'sh010000;  // 1.0 in Q8.16
    localparam logic signed [GAIN_W-1:0] GAIN_MAX = 24'sh7FFFFF;
    localparam logic signed [GAIN_W-1:0] GAIN_MIN = 24'sh800000;

    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > 40'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -40'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[SMP_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ sv/adsr_ram.sv @@
module adsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/adsr_envelope_generator_core.sv @@
// Channel   Handshake          Carries
// cfg       cfg_we             cfg_index, cfg_data (stage lengths, 24 bit)
// s_        s_valid / s_ready  s_func, s_sample_in, s_table_stage/index/value
// m_        m_valid / m_ready  m_sample_out, m_stage_now
//
// Gate and table-write items leave the sequencer idle. A sample item holds the block
// until its result is handed over. The shared restoring divider forms the curve index
// one quotient bit per cycle; empty stages are passed over in ST_SKIP, release adds
// ST_MUL and ST_SCALE for the multiply, and the first release sample above zero runs
// the divider again for the gain unless it saturates. s_ready is high only while the
// sequencer is idle. A finished result sits in the output register; a new item is
// accepted meanwhile and stalls only at its own hand-over. Reset is synchronous, low.
module adsr_envelope_generator_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int FRAME_BITS  = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic signed [15:0] s_sample_in,
    input  logic [1:0]         s_table_stage,
    input  logic [9:0]         s_table_index,
    input  logic signed [15:0] s_table_value,
    // result items
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample_out,
    output logic [2:0]         m_stage_now
);

    localparam int QB = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1; // index bits
    localparam int DB = $clog2(TABLE_DEPTH + 1);                      // bits of DEPTH
    localparam int NW = FRAME_BITS + DB;
    localparam int DW = (NW > 39) ? NW : 39;                          // divider width
    localparam int CW = (FRAME_BITS > 24) ? FRAME_BITS : 24;          // length compare
    localparam int AW = $clog2(4 * TABLE_DEPTH);
    localparam int QW = adsr_pkg::GAIN_QW;

    localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};

    // ---------------------------------------------------------------- state
    adsr_pkg::state_t                 state_reg, state_next;
    adsr_pkg::stage_t                 stage_reg, stage_next;
    logic [FRAME_BITS-1:0]            frame_reg, frame_next;
    logic signed [adsr_pkg::GAIN_W-1:0] gain_reg, gain_next;
    logic [23:0]                      attack_len_reg, attack_len_next;
    logic [23:0]                      decay_len_reg, decay_len_next;
    logic [23:0]                      sustain_len_reg, sustain_len_next;
    logic [23:0]                      release_len_reg, release_len_next;
    logic                             m_valid_reg, m_valid_next;

    // payload / datapath
    logic signed [15:0]               x_reg, x_next;
    logic signed [15:0]               y_reg, y_next;
    logic [DW-1:0]                    rem_reg, rem_next;
    logic [DW-1:0]                    dsh_reg, dsh_next;
    logic [QW-1:0]                    q_reg, q_next;
    logic [adsr_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                             div_gain_reg, div_gain_next;
    logic signed [adsr_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [15:0]               m_sample_out_reg, m_sample_out_next;
    logic [2:0]                       m_stage_now_reg, m_stage_now_next;

    // ---------------------------------------------------------------- curve memory
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;
    logic [1:0]    row;
    logic          s_acc;

    assign s_ready = (state_reg == adsr_pkg::ST_IDLE);
    assign s_acc   = s_valid && s_ready;

    assign ram_we    = s_acc && (adsr_pkg::func_t'(s_func) == adsr_pkg::FN_TABLE_WR)
                       && (32'(s_table_index) < 32'(TABLE_DEPTH));
    assign ram_waddr = AW'(s_table_stage) * AW'(TABLE_DEPTH) + AW'(s_table_index);

    // curve row: attack is row 0 ... release row 3
    assign row = 2'(3'(stage_reg) - 3'd1);

    always_comb begin
        if (state_reg == adsr_pkg::ST_HOLD_RD) begin
            ram_raddr = AW'(2) * AW'(TABLE_DEPTH) + AW'(TABLE_DEPTH - 1);
        end else begin
            ram_raddr = AW'(row) * AW'(TABLE_DEPTH) + AW'(q_reg[QB-1:0]);
        end
    end

    adsr_ram #(
        .WIDTH(16),
        .DEPTH(4 * TABLE_DEPTH)
    ) u_curve_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(s_table_value),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // ---------------------------------------------------------------- shared divider step
    // Restoring division, one quotient bit per cycle; dsh holds divisor << bit.
    logic          div_ge;
    logic [DW-1:0] div_rem;

    assign div_ge  = (rem_reg >= dsh_reg);
    assign div_rem = div_ge ? (rem_reg - dsh_reg) : rem_reg;

    // ---------------------------------------------------------------- helpers
    logic [23:0]                      cur_len;
    logic                             frame_ge;
    logic signed [15:0]               y_sum;
    logic [adsr_pkg::GAIN_W-1:0]      g_mag;
    logic                             gain_sat;
    logic signed [adsr_pkg::PROD_W-1:0] prod_adj;
    logic [FRAME_BITS-1:0]            frame_inc;

    always_comb begin
        unique case (stage_reg)
            adsr_pkg::STG_ATTACK:  cur_len = attack_len_reg;
            adsr_pkg::STG_DECAY:   cur_len = decay_len_reg;
            adsr_pkg::STG_SUSTAIN: cur_len = sustain_len_reg;
            default:               cur_len = release_len_reg;
        endcase
    end

    assign frame_ge  = (CW'(frame_reg) >= CW'(cur_len));
    assign frame_inc = (frame_reg != FRAME_MAX) ? frame_reg + 1'b1 : frame_reg;
    assign y_sum     = adsr_pkg::sat16(40'(x_reg) + 40'($signed(ram_rdata)));
    assign g_mag     = gain_reg[23] ? 24'(-gain_reg) : 24'(gain_reg);
    // quotient would reach 2^23: saturate without dividing
    assign gain_sat  = (g_mag >= {1'b0, y_sum[14:0], 8'b0});
    assign prod_adj  = prod_reg + (prod_reg[39] ? 40'sd65535 : 40'sd0);

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next        = state_reg;
        stage_next        = stage_reg;
        frame_next        = frame_reg;
        gain_next         = gain_reg;
        attack_len_next   = attack_len_reg;
        decay_len_next    = decay_len_reg;
        sustain_len_next  = sustain_len_reg;
        release_len_next  = release_len_reg;
        m_valid_next      = m_valid_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        rem_next          = rem_reg;
        dsh_next          = dsh_reg;
        q_next            = q_reg;
        cnt_next          = cnt_reg;
        div_gain_next     = div_gain_reg;
        prod_next         = prod_reg;
        m_sample_out_next = m_sample_out_reg;
        m_stage_now_next  = m_stage_now_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                adsr_pkg::REG_ATTACK_LEN:  attack_len_next  = cfg_data;
                adsr_pkg::REG_DECAY_LEN:   decay_len_next   = cfg_data;
                adsr_pkg::REG_SUSTAIN_LEN: sustain_len_next = cfg_data;
                adsr_pkg::REG_RELEASE_LEN: release_len_next = cfg_data;
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            adsr_pkg::ST_IDLE: begin
                if (s_acc) begin
                    unique case (adsr_pkg::func_t'(s_func))
                        adsr_pkg::FN_GATE_ON: begin
                            frame_next = '0;
                            stage_next = adsr_pkg::STG_ATTACK;
                        end
                        adsr_pkg::FN_GATE_OFF: begin
                            frame_next = '0;
                            stage_next = adsr_pkg::STG_RELEASE;
                        end
                        adsr_pkg::FN_TABLE_WR: ;  // written straight into the RAM
                        default: begin
                            x_next = s_sample_in;
                            if (stage_reg == adsr_pkg::STG_SILENT) begin
                                y_next     = s_sample_in;  // pass through
                                state_next = adsr_pkg::ST_OUT;
                            end else begin
                                state_next = adsr_pkg::ST_SKIP;
                            end
                        end
                    endcase
                end
            end

            adsr_pkg::ST_SKIP: begin
                priority if ((stage_reg == adsr_pkg::STG_ATTACK ||
                              stage_reg == adsr_pkg::STG_DECAY) && frame_ge) begin
                    // finished or empty stage: move on
                    stage_next = (stage_reg == adsr_pkg::STG_ATTACK) ?
                                 adsr_pkg::STG_DECAY : adsr_pkg::STG_SUSTAIN;
                    frame_next = '0;
                end else if (stage_reg == adsr_pkg::STG_SUSTAIN && frame_ge) begin
                    state_next = adsr_pkg::ST_HOLD_RD;
                end else if (stage_reg == adsr_pkg::STG_RELEASE && frame_ge) begin
                    y_next     = '0;
                    stage_next = adsr_pkg::STG_SILENT;
                    frame_next = '0;
                    gain_next  = '0;
                    state_next = adsr_pkg::ST_OUT;
                end else begin
                    // index = frame * DEPTH / len, quotient below DEPTH
                    rem_next      = DW'(frame_reg) * DW'(TABLE_DEPTH);
                    dsh_next      = DW'(cur_len) << (QB - 1);
                    q_next        = '0;
                    cnt_next      = adsr_pkg::CNT_W'(QB - 1);
                    div_gain_next = 1'b0;
                    state_next    = adsr_pkg::ST_DIV;
                end
            end

            adsr_pkg::ST_DIV: begin
                rem_next = div_rem;
                dsh_next = dsh_reg >> 1;
                q_next   = {q_reg[QW-2:0], div_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    if (div_gain_reg) begin
                        gain_next  = gain_reg[23] ? -$signed({1'b0, q_next}) :
                                                     $signed({1'b0, q_next});
                        state_next = adsr_pkg::ST_MUL;
                    end else begin
                        state_next = adsr_pkg::ST_RD;
                    end
                end
            end

            adsr_pkg::ST_RD: begin
                state_next = adsr_pkg::ST_SUM;
            end

            adsr_pkg::ST_SUM: begin
                y_next     = y_sum;
                frame_next = frame_inc;
                if (stage_reg == adsr_pkg::STG_RELEASE) begin
                    if (frame_reg == '0 && y_sum > 16'sd0) begin
                        // gain = gain * 32768 / y, by magnitude
                        if (gain_sat) begin
                            gain_next  = gain_reg[23] ? adsr_pkg::GAIN_MIN : adsr_pkg::GAIN_MAX;
                            state_next = adsr_pkg::ST_MUL;
                        end else begin
                            rem_next      = DW'({g_mag, 15'b0});
                            dsh_next      = DW'(y_sum[14:0]) << (QW - 1);
                            q_next        = '0;
                            cnt_next      = adsr_pkg::CNT_W'(QW - 1);
                            div_gain_next = 1'b1;
                            state_next    = adsr_pkg::ST_DIV;
                        end
                    end else begin
                        state_next = adsr_pkg::ST_MUL;
                    end
                end else begin
                    gain_next  = {{7{y_sum[15]}}, y_sum, 1'b0};
                    state_next = adsr_pkg::ST_OUT;
                end
            end

            adsr_pkg::ST_MUL: begin
                prod_next  = 40'(y_reg) * 40'(gain_reg);
                state_next = adsr_pkg::ST_SCALE;
            end

            adsr_pkg::ST_SCALE: begin
                y_next     = adsr_pkg::sat16(prod_adj >>> 16);
                state_next = adsr_pkg::ST_OUT;
            end

            adsr_pkg::ST_HOLD_RD: begin
                state_next = adsr_pkg::ST_HOLD;
            end

            adsr_pkg::ST_HOLD: begin
                // sustain over: hold the last entry, input ignored
                y_next     = $signed(ram_rdata);
                gain_next  = {{7{ram_rdata[15]}}, ram_rdata, 1'b0};
                state_next = adsr_pkg::ST_OUT;
            end

            adsr_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_sample_out_next = y_reg;
                    m_stage_now_next  = 3'(stage_reg);
                    state_next        = adsr_pkg::ST_IDLE;
                end
            end

            default: state_next = adsr_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= adsr_pkg::ST_IDLE;
            stage_reg       <= adsr_pkg::STG_SILENT;
            frame_reg       <= '0;
            gain_reg        <= adsr_pkg::GAIN_ONE;
            attack_len_reg  <= '0;
            decay_len_reg   <= '0;
            sustain_len_reg <= '0;
            release_len_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            stage_reg       <= stage_next;
            frame_reg       <= frame_next;
            gain_reg        <= gain_next;
            attack_len_reg  <= attack_len_next;
            decay_len_reg   <= decay_len_next;
            sustain_len_reg <= sustain_len_next;
            release_len_reg <= release_len_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg            <= x_next;
        y_reg            <= y_next;
        rem_reg          <= rem_next;
        dsh_reg          <= dsh_next;
        q_reg            <= q_next;
        cnt_reg          <= cnt_next;
        div_gain_reg     <= div_gain_next;
        prod_reg         <= prod_next;
        m_sample_out_reg <= m_sample_out_next;
        m_stage_now_reg  <= m_stage_now_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;
    assign m_stage_now  = m_stage_now_reg;

endmodule
